// ===== design/tpq_pkg.sv =====
// shared types and constants of the tag presence qualifier
package tpq_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned ID_W    = 64;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned RPT_W   = 4;
    localparam int unsigned CIDX_W  = 8;
    localparam int unsigned CDATA_W = 16;
    localparam int unsigned S_DATA_W = 96;
    localparam int unsigned M_DATA_W = 168;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_SCAN_INTERVAL  = 8'd0;
    localparam logic [CIDX_W-1:0] REG_REMOVAL_TMO    = 8'd1;
    localparam logic [CIDX_W-1:0] REG_CONFIRM_READS  = 8'd2;
    localparam logic [CIDX_W-1:0] REG_QUIET_LIMIT    = 8'd3;

    // register reset values
    localparam logic [15:0] RST_SCAN_INTERVAL = 16'd250;
    localparam logic [15:0] RST_REMOVAL_TMO   = 16'd1000;
    localparam logic [3:0]  RST_CONFIRM_READS = 4'd2;
    localparam logic [7:0]  RST_QUIET_LIMIT   = 8'd10;

    // scan outcome codes
    localparam logic [1:0] SCAN_OK     = 2'd0;
    localparam logic [1:0] SCAN_NO_TAG = 2'd1;
    localparam logic [1:0] SCAN_ERROR  = 2'd2;

    // event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESENT = 2'd1;
    localparam logic [1:0] EV_REMOVED = 2'd2;

    // status codes
    localparam logic [1:0] ST_SCANNING = 2'd0;
    localparam logic [1:0] ST_PRESENT  = 2'd1;
    localparam logic [1:0] ST_NO_TAG   = 2'd2;

    localparam logic [RPT_W-1:0] RPT_MAX = 4'd15;
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef struct packed {
        logic [15:0] scan_interval_ms;
        logic [15:0] removal_timeout_ms;
        logic [3:0]  confirm_reads;
        logic [7:0]  quiet_scan_limit;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [1:0]        scan_result;
        logic [ID_W-1:0]   tag_id;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] last_scan_time;
        logic [ID_W-1:0]   candidate_id;
        logic              candidate_valid;
        logic [RPT_W-1:0]  repeat_count;
        logic [ID_W-1:0]   confirmed_id;
        logic              confirmed_valid;
        logic              tag_present;
        logic [TIME_W-1:0] last_seen_time;
        logic [CNT_W-1:0]  scans;
        logic [CNT_W-1:0]  good_reads;
        logic [CNT_W-1:0]  failed_reads;
        logic [1:0]        status;
    } state_t;

    typedef struct packed {
        logic [1:0]       event_res;
        logic [ID_W-1:0]  event_id;
        logic             present_flag;
        logic [1:0]       status_code;
        logic [CNT_W-1:0] scan_count;
        logic [CNT_W-1:0] good_count;
        logic [CNT_W-1:0] fail_count;
    } result_t;

endpackage

// ===== design/tag_presence_qualifier_unit.sv =====
// top level of the tag presence qualifier
//
// Qualifies polls from a tag reader. Every accepted slave-side transaction is one
// poll and yields exactly one master-side transaction, in order. A poll arriving
// before scan_interval_ms has elapsed since the last taken scan leaves the state
// unchanged and reports the current counters with no event. A tag is reported
// present after confirm_reads identical consecutive valid reads, and removed once
// no confirmation has happened for more than removal_timeout_ms. The block takes
// one poll per clock while the output is not stalled: a poll waits in the input
// register, the poll logic and the state register close their loop while it is
// there, and the result lands in the output register, which may hold under
// back-pressure while the next poll waits in the input register. m_tvalid rises
// once the result is in the output register, after the poll has passed through
// the input register. Configuration is written through the cfg
// channel, always ready, and must only be written while no poll is in flight.
module tag_presence_qualifier_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    // slave side
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tpq_pkg::S_DATA_W-1:0] s_tdata,   // now_ms[31:0], tag_id[95:32]
    input  logic [1:0]                   s_tuser,   // scan_result[1:0]
    // master side
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // event_id[63:0], present_flag[64], status_code[66:65], scan_count[98:67],
    // good_count[130:99], fail_count[162:131], zero fill[167:163]
    output logic [tpq_pkg::M_DATA_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser,   // event_res[1:0]
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tpq_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [tpq_pkg::CDATA_W-1:0]  cfg_data
);

    tpq_pkg::cfg_t    cfg;
    tpq_pkg::item_t   item_reg;
    logic             item_valid_reg;
    tpq_pkg::state_t  state_reg;
    tpq_pkg::state_t  state_next;
    tpq_pkg::result_t result;
    tpq_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             in_xfer;

    // config registers are always writable
    assign cfg_ready = 1'b1;

    tpq_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the poll in the input register moves on when the output slot frees up
    assign advance  = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (s_tready)
            item_valid_reg <= s_tvalid;
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.now_ms      <= s_tdata[31:0];
            item_reg.scan_result <= s_tuser;
            item_reg.tag_id      <= s_tdata[95:32];
        end
    end

    tpq_poll_logic u_poll
    (
        .item       (item_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // qualifier state commits once per poll as it leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {5'd0, out_reg.fail_count, out_reg.good_count, out_reg.scan_count,
                       out_reg.status_code, out_reg.present_flag, out_reg.event_id};

endmodule

// ===== design/tpq_cfg_regs.sv =====
// configuration register bank of the tag presence qualifier
module tpq_cfg_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [tpq_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [tpq_pkg::CDATA_W-1:0] cfg_data,
    output tpq_pkg::cfg_t              cfg
);

    tpq_pkg::cfg_t cfg_reg;
    tpq_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tpq_pkg::REG_SCAN_INTERVAL: cfg_next.scan_interval_ms   = cfg_data;
                tpq_pkg::REG_REMOVAL_TMO:   cfg_next.removal_timeout_ms = cfg_data;
                tpq_pkg::REG_CONFIRM_READS: cfg_next.confirm_reads      = cfg_data[3:0];
                tpq_pkg::REG_QUIET_LIMIT:   cfg_next.quiet_scan_limit   = cfg_data[7:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_interval_ms   <= tpq_pkg::RST_SCAN_INTERVAL;
            cfg_reg.removal_timeout_ms <= tpq_pkg::RST_REMOVAL_TMO;
            cfg_reg.confirm_reads      <= tpq_pkg::RST_CONFIRM_READS;
            cfg_reg.quiet_scan_limit   <= tpq_pkg::RST_QUIET_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/tpq_poll_logic.sv =====
// per-poll next-state and result logic of the tag presence qualifier
module tpq_poll_logic
(
    input  tpq_pkg::item_t   item,
    input  tpq_pkg::cfg_t    cfg,
    input  tpq_pkg::state_t  state,
    output tpq_pkg::state_t  state_next,
    output tpq_pkg::result_t result
);

    logic                        id_valid;
    logic [tpq_pkg::TIME_W-1:0]  scan_elapsed;
    logic [tpq_pkg::TIME_W-1:0]  seen_elapsed;
    logic [tpq_pkg::CNT_W-1:0]   scans_inc;
    logic                        scan_taken;
    logic                        cand_match;
    logic [tpq_pkg::RPT_W-1:0]   rpt_new;
    logic                        check_rm;
    logic [1:0]                  ev;
    logic [tpq_pkg::ID_W-1:0]    ev_id;

    // a valid id has at least one byte that is neither all zeros nor all ones
    always_comb
    begin
        id_valid = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (item.tag_id[8*i +: 8] != tpq_pkg::BYTE_ZERO &&
                item.tag_id[8*i +: 8] != tpq_pkg::BYTE_ONES)
            begin
                id_valid = 1'b1;
            end
        end
    end

    assign scan_elapsed = item.now_ms - state.last_scan_time;
    assign seen_elapsed = item.now_ms - state.last_seen_time;
    assign scan_taken   = scan_elapsed >= {16'd0, cfg.scan_interval_ms};
    assign scans_inc    = state.scans + 32'd1;
    assign cand_match   = state.candidate_valid && (state.candidate_id == item.tag_id);

    always_comb
    begin
        if (!cand_match)
            rpt_new = 4'd1;
        else if (state.repeat_count < tpq_pkg::RPT_MAX)
            rpt_new = state.repeat_count + 4'd1;
        else
            rpt_new = state.repeat_count;
    end

    always_comb
    begin
        state_next = state;
        ev         = tpq_pkg::EV_NONE;
        ev_id      = '0;
        check_rm   = 1'b0;
        if (scan_taken)
        begin
            state_next.last_scan_time = item.now_ms;
            state_next.scans          = scans_inc;
            unique case (item.scan_result)
                tpq_pkg::SCAN_OK:
                begin
                    if (!id_valid)
                    begin
                        state_next.failed_reads    = state.failed_reads + 32'd1;
                        state_next.repeat_count    = '0;
                        state_next.candidate_valid = 1'b0;
                        state_next.candidate_id    = '0;
                        check_rm                   = 1'b1;
                    end
                    else
                    begin
                        state_next.good_reads      = state.good_reads + 32'd1;
                        state_next.candidate_id    = item.tag_id;
                        state_next.candidate_valid = 1'b1;
                        state_next.repeat_count    = rpt_new;
                        if (rpt_new >= cfg.confirm_reads)
                        begin
                            // new id takes over, same id just refreshes
                            if (!state.confirmed_valid || state.confirmed_id != item.tag_id)
                            begin
                                state_next.confirmed_id    = item.tag_id;
                                state_next.confirmed_valid = 1'b1;
                                state_next.status          = tpq_pkg::ST_PRESENT;
                            end
                            state_next.tag_present    = 1'b1;
                            state_next.last_seen_time = item.now_ms;
                            ev                        = tpq_pkg::EV_PRESENT;
                            ev_id                     = item.tag_id;
                        end
                    end
                end
                tpq_pkg::SCAN_NO_TAG:
                begin
                    check_rm = 1'b1;
                end
                default:
                begin
                    // reader error and the unused code
                    state_next.failed_reads    = state.failed_reads + 32'd1;
                    state_next.repeat_count    = '0;
                    state_next.candidate_valid = 1'b0;
                    state_next.candidate_id    = '0;
                    if (state.good_reads != '0 || scans_inc > {24'd0, cfg.quiet_scan_limit})
                        state_next.status = tpq_pkg::ST_NO_TAG;
                    check_rm = 1'b1;
                end
            endcase
            if (check_rm && state.tag_present &&
                seen_elapsed > {16'd0, cfg.removal_timeout_ms})
            begin
                state_next.tag_present     = 1'b0;
                state_next.status          = tpq_pkg::ST_SCANNING;
                ev                         = tpq_pkg::EV_REMOVED;
                ev_id                      = state.confirmed_valid ? state.confirmed_id : '0;
                state_next.confirmed_id    = '0;
                state_next.confirmed_valid = 1'b0;
            end
        end
    end

    always_comb
    begin
        result.event_res    = ev;
        result.event_id     = ev_id;
        result.present_flag = state_next.tag_present;
        result.status_code  = state_next.status;
        result.scan_count   = state_next.scans;
        result.good_count   = state_next.good_reads;
        result.fail_count   = state_next.failed_reads;
    end

endmodule

// ===== design/tpq_checker.sv =====
// port-level assertions of the tag presence qualifier and their bind
module tpq_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [tpq_pkg::M_DATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a result with no event carries a zero id
    a_none_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == tpq_pkg::EV_NONE |-> m_tdata[63:0] == '0)
        else $error("event id nonzero without event");

    // removal leaves no tag and scanning status, presence leaves a tag
    a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            (m_tuser != tpq_pkg::EV_REMOVED ||
             (!m_tdata[64] && m_tdata[66:65] == tpq_pkg::ST_SCANNING)) &&
            (m_tuser != tpq_pkg::EV_PRESENT || m_tdata[64]))
        else $error("event disagrees with presence flag or status");

    // status tag present only while a tag is present
    a_status_present: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[66:65] == tpq_pkg::ST_PRESENT |-> m_tdata[64])
        else $error("present status without present tag");

endmodule

bind tag_presence_qualifier_unit tpq_checker u_tpq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== bench/tag_presence_predictor_pkg.sv =====
// scoreboard class: tag presence predictor and result check for the qualifier bench
`timescale 1ns / 100ps

package tag_presence_predictor_pkg;

    import tpq_pkg::*;

    class tag_presence_predictor;

        // register copies
        logic [15:0]      min_gap;
        logic [15:0]      removal_timeout;
        logic [3:0]       confirm_needed;
        logic [7:0]       quiet_limit;

        // qualifier state
        logic [TIME_W-1:0] last_scan_time;
        logic [TIME_W-1:0] last_seen_time;
        logic [ID_W-1:0]   candidate_id;
        logic [ID_W-1:0]   confirmed_id;
        bit                candidate_valid;
        bit                confirmed_valid;
        bit                tag_present;
        logic [RPT_W-1:0]  repeat_count;
        logic [CNT_W-1:0]  scans;
        logic [CNT_W-1:0]  good_reads;
        logic [CNT_W-1:0]  failed_reads;
        logic [1:0]        status;

        result_t           expected_reports[$];
        int unsigned       failures;

        function new();
            min_gap         = RST_SCAN_INTERVAL;
            removal_timeout = RST_REMOVAL_TMO;
            confirm_needed  = RST_CONFIRM_READS;
            quiet_limit     = RST_QUIET_LIMIT;
            last_scan_time  = '0;
            last_seen_time  = '0;
            candidate_id    = '0;
            confirmed_id    = '0;
            candidate_valid = 1'b0;
            confirmed_valid = 1'b0;
            tag_present     = 1'b0;
            repeat_count    = '0;
            scans           = '0;
            good_reads      = '0;
            failed_reads    = '0;
            status          = ST_SCANNING;
            failures        = 0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] index, logic [CDATA_W-1:0] data);
            unique case (index)
                REG_SCAN_INTERVAL: min_gap         = data;
                REG_REMOVAL_TMO:   removal_timeout = data;
                REG_CONFIRM_READS: confirm_needed  = data[3:0];
                REG_QUIET_LIMIT:   quiet_limit     = data[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        // an id is readable unless every byte is all zeros or all ones
        function bit id_readable(logic [ID_W-1:0] id);
            logic [7:0] b;
            for (int i = 0; i < 8; i++) begin
                b = id[8*i +: 8];
                if (b != BYTE_ZERO && b != BYTE_ONES)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void drop_candidate();
            failed_reads++;
            repeat_count    = '0;
            candidate_valid = 1'b0;
            candidate_id    = '0;
        endfunction

        function void check_removal(logic [TIME_W-1:0] now, inout result_t r);
            logic [TIME_W-1:0] unseen;
            unseen = now - last_seen_time;
            if (tag_present && unseen > {16'd0, removal_timeout}) begin
                tag_present     = 1'b0;
                status          = ST_SCANNING;
                r.event_res     = EV_REMOVED;
                r.event_id      = confirmed_valid ? confirmed_id : '0;
                confirmed_id    = '0;
                confirmed_valid = 1'b0;
            end
        endfunction

        // one accepted poll gives exactly one expected report
        function void note_poll(item_t p);
            result_t           r;
            logic [TIME_W-1:0] since_scan;
            r          = '0;
            since_scan = p.now_ms - last_scan_time;
            if (since_scan >= {16'd0, min_gap}) begin
                last_scan_time = p.now_ms;
                scans++;
                if (p.scan_result == SCAN_OK) begin
                    if (!id_readable(p.tag_id)) begin
                        drop_candidate();
                        check_removal(p.now_ms, r);
                    end else begin
                        good_reads++;
                        if (candidate_valid && candidate_id == p.tag_id) begin
                            if (repeat_count < RPT_MAX)
                                repeat_count++;
                        end else begin
                            candidate_id    = p.tag_id;
                            candidate_valid = 1'b1;
                            repeat_count    = 4'd1;
                        end
                        if (repeat_count >= confirm_needed) begin
                            if (!confirmed_valid || confirmed_id != p.tag_id) begin
                                confirmed_id    = p.tag_id;
                                confirmed_valid = 1'b1;
                                status          = ST_PRESENT;
                            end
                            tag_present    = 1'b1;
                            last_seen_time = p.now_ms;
                            r.event_res    = EV_PRESENT;
                            r.event_id     = p.tag_id;
                        end
                    end
                end else if (p.scan_result == SCAN_NO_TAG) begin
                    check_removal(p.now_ms, r);
                end else begin
                    drop_candidate();
                    if (good_reads != 0 || scans > {24'd0, quiet_limit})
                        status = ST_NO_TAG;
                    check_removal(p.now_ms, r);
                end
            end
            r.present_flag = tag_present;
            r.status_code  = status;
            r.scan_count   = scans;
            r.good_count   = good_reads;
            r.fail_count   = failed_reads;
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0h, actual %0h", name, want, seen);
                failures++;
            end
        endfunction

        function void check_report(result_t got);
            result_t want;
            if (expected_reports.size() == 0) begin
                $error("report with no poll waiting for it");
                failures++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("event_res",    ID_W'(want.event_res),    ID_W'(got.event_res));
            compare_field("event_id",     want.event_id,            got.event_id);
            compare_field("present_flag", ID_W'(want.present_flag), ID_W'(got.present_flag));
            compare_field("status_code",  ID_W'(want.status_code),  ID_W'(got.status_code));
            compare_field("scan_count",   ID_W'(want.scan_count),   ID_W'(got.scan_count));
            compare_field("good_count",   ID_W'(want.good_count),   ID_W'(got.good_count));
            compare_field("fail_count",   ID_W'(want.fail_count),   ID_W'(got.fail_count));
        endfunction

    endclass

endpackage

// ===== bench/tag_presence_qualifier_unit_tb.sv =====
// testbench top: drives polls and register writes into the qualifier and checks every report
`timescale 1ns / 100ps

module tag_presence_qualifier_unit_tb;

    import tpq_pkg::*;
    import tag_presence_predictor_pkg::*;

    // outcome code the reader never sends; the block treats it as a reader error
    localparam logic [1:0] SCAN_UNUSED = 2'd3;

    localparam int HOLD_OFF_CYCLES = 300;     // long receiver stall, fills the pipeline
    localparam int DRAIN_CYCLES    = 4;       // margin after the last report
    localparam int PHASES          = 6;
    localparam int POLLS_PER_PHASE = 150;
    localparam int CYCLE_LIMIT     = 400000;  // watchdog bound on the run length

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;    // now_ms[31:0], tag_id[95:32]
    logic [1:0]            s_tuser   = '0;    // scan_result[1:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // event_id[63:0], present_flag[64], status_code[66:65], scan_count[98:67],
    // good_count[130:99], fail_count[162:131]
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;           // event_res[1:0]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CIDX_W-1:0]     cfg_index = '0;
    logic [CDATA_W-1:0]    cfg_data  = '0;

    tag_presence_predictor sb;

    // stimulus bookkeeping
    logic [TIME_W-1:0]     clock_ms;          // millisecond time seen by the reader
    logic [ID_W-1:0]       tag_pool[4];       // tags that come and go in front of the reader
    int                    held_tag;          // index into tag_pool, -1 when the field is empty
    logic [15:0]           cur_interval;
    logic [15:0]           cur_timeout;
    bit                    sender_calm;       // back-to-back stretch on the slave side
    bit                    hold_off_req;      // asks the receiver for one long stall
    int unsigned           cycle_count;

    tag_presence_qualifier_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog: a lost report or a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tag_presence_qualifier_unit_tb: FAIL");
        $finish;
    end

    function automatic logic [ID_W-1:0] random_tag();
        return {$urandom, $urandom};
    endfunction

    // every byte all zeros or all ones: an unreadable id
    function automatic logic [ID_W-1:0] blank_tag();
        logic [ID_W-1:0] id;
        for (int i = 0; i < 8; i++)
            id[8*i +: 8] = $urandom_range(0, 1) ? BYTE_ONES : BYTE_ZERO;
        return id;
    endfunction

    // next poll of the random part: time mostly steps by about one scan interval,
    // with early polls, removal-sized gaps and wild jumps mixed in
    function automatic item_t next_poll();
        item_t             p;
        int                pick;
        logic [TIME_W-1:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            step = cur_interval + $urandom_range(0, 40);
        else if (pick < 80)
            step = $urandom_range(0, cur_interval);
        else if (pick < 95)
            step = cur_timeout + $urandom_range(0, 400);
        else
            step = $urandom;
        clock_ms = clock_ms + step;
        p.now_ms = clock_ms;
        p.tag_id = random_tag();

        // tags enter and leave the field now and then
        if ($urandom_range(0, 19) == 0)
            held_tag = int'($urandom_range(0, 4)) - 1;

        pick = $urandom_range(0, 99);
        if (held_tag >= 0)
        begin
            if (pick < 78)
            begin
                p.scan_result = SCAN_OK;
                p.tag_id      = tag_pool[held_tag];
            end
            else if (pick < 84)
                p.scan_result = SCAN_OK;
            else if (pick < 88)
            begin
                p.scan_result = SCAN_OK;
                p.tag_id      = blank_tag();
            end
            else if (pick < 94)
                p.scan_result = SCAN_NO_TAG;
            else if (pick < 97)
                p.scan_result = SCAN_ERROR;
            else
                p.scan_result = SCAN_UNUSED;
        end
        else
        begin
            if (pick < 50)
                p.scan_result = SCAN_NO_TAG;
            else if (pick < 70)
                p.scan_result = SCAN_ERROR;
            else if (pick < 78)
                p.scan_result = SCAN_UNUSED;
            else if (pick < 88)
            begin
                p.scan_result = SCAN_OK;
                p.tag_id      = blank_tag();
            end
            else
                p.scan_result = SCAN_OK;
        end
        return p;
    endfunction

    // offer one poll after a random gap and wait for the slave-side transaction;
    // tvalid stays high afterwards so back-to-back polls need no extra edge
    task automatic send_poll(input item_t p);
        int gap;
        if ($urandom_range(0, 39) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.tag_id, p.now_ms};
        s_tuser  <= p.scan_result;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_poll(p);
    endtask

    task automatic poll(input logic [TIME_W-1:0] now, input logic [1:0] outcome,
                        input logic [ID_W-1:0] id);
        item_t p;
        p.now_ms      = now;
        p.scan_result = outcome;
        p.tag_id      = id;
        send_poll(p);
    endtask

    // master side: random stalls, calm stretches and one long hold-off on request
    task automatic receive_reports();
        int      stall;
        bit      calm;
        result_t got;
        calm = 1'b0;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.event_res    = m_tuser;
            got.event_id     = m_tdata[63:0];
            got.present_flag = m_tdata[64];
            got.status_code  = m_tdata[66:65];
            got.scan_count   = m_tdata[98:67];
            got.good_count   = m_tdata[130:99];
            got.fail_count   = m_tdata[162:131];
            sb.check_report(got);
        end
    endtask

    // stop offering polls and wait until every report has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write transaction; cfg_valid is lowered by the caller after a batch
    task automatic put_reg(input logic [CIDX_W-1:0] index, input logic [CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(index, data);
        if (index == REG_SCAN_INTERVAL)
            cur_interval = data;
        if (index == REG_REMOVAL_TMO)
            cur_timeout = data;
    endtask

    task automatic configure(input logic [15:0] interval, input logic [15:0] timeout,
                             input logic [3:0] confirm, input logic [7:0] quiet);
        put_reg(REG_SCAN_INTERVAL, interval);
        put_reg(REG_REMOVAL_TMO, timeout);
        put_reg(REG_CONFIRM_READS, {12'd0, confirm});
        put_reg(REG_QUIET_LIMIT, {8'd0, quiet});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [ID_W-1:0] tag_a;
        logic [ID_W-1:0] tag_b;

        sb           = new();
        cur_interval = RST_SCAN_INTERVAL;
        cur_timeout  = RST_REMOVAL_TMO;
        sender_calm  = 1'b0;
        hold_off_req = 1'b0;
        held_tag     = -1;
        for (int i = 0; i < 4; i++)
            tag_pool[i] = random_tag();
        tag_a = tag_pool[0];
        tag_b = tag_pool[1];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            receive_reports();
        join_none

        // directed part, reset register values first
        poll(32'd0,    SCAN_OK,     tag_a);                 // too early after reset, ignored
        poll(32'd100,  SCAN_ERROR,  random_tag());          // still too early
        poll(32'd250,  SCAN_NO_TAG, random_tag());          // exactly one interval later
        poll(32'd500,  SCAN_ERROR,  random_tag());          // few scans, no good read: status stays
        poll(32'd750,  SCAN_OK,     '0);                    // all-zero id
        poll(32'd1000, SCAN_OK,     '1);                    // all-ones id
        poll(32'd1250, SCAN_OK,     64'hFF00_FF00_00FF_FF00); // zero and ones bytes mixed

        // low quiet limit: next error reports no tag in range with no good read yet
        settle();
        put_reg(REG_QUIET_LIMIT, 16'd3);
        cfg_valid <= 1'b0;
        poll(32'd1500, SCAN_ERROR,  random_tag());

        poll(32'd1750, SCAN_OK,     tag_a);                 // first sighting
        poll(32'd2000, SCAN_OK,     tag_a);                 // confirmed, tag present
        poll(32'd2250, SCAN_OK,     tag_a);                 // refresh of the present tag
        poll(32'd2500, SCAN_OK,     tag_b);                 // other tag, new candidate
        poll(32'd2750, SCAN_OK,     tag_b);                 // new tag replaces the old
        poll(32'd3750, SCAN_NO_TAG, random_tag());          // exactly the timeout, no removal
        poll(32'd4001, SCAN_NO_TAG, random_tag());          // past the timeout, removal
        poll(32'd4251, SCAN_UNUSED, random_tag());          // unused outcome acts as an error
        poll(32'd4501, SCAN_OK,     tag_a);
        poll(32'd4751, SCAN_OK,     tag_a);                 // returning tag
        poll(32'd5001, SCAN_ERROR,  random_tag());          // error while present
        poll(32'd5251, SCAN_OK,     tag_a);                 // candidate was cleared, counts again
        poll(32'd5501, SCAN_OK,     tag_a);                 // confirmed again, status untouched
        poll(32'hFFFF_FF00, SCAN_ERROR, random_tag());      // huge gap, removal
        poll(32'h0000_0010, SCAN_OK, 64'hFFFF_FFFF_FFFF_FFFE); // time wraps, highest valid id
        poll(32'h0000_0100, SCAN_NO_TAG, random_tag());     // short gap across the wrap, ignored
        clock_ms = 32'h0000_0100;

        // random part: one register setting per phase, extremes first
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            if (phase == 0)
                configure(16'd0, 16'd0, 4'd0, 8'd0);
            else if (phase == 1)
                configure(16'hFFFF, 16'hFFFF, 4'd15, 8'hFF);
            else
            begin
                // writes to an unused index must leave every register alone
                if (phase == 3)
                    put_reg(REG_QUIET_LIMIT + 8'd1, 16'($urandom));
                configure(16'($urandom_range(0, 400)), 16'($urandom_range(0, 2500)),
                          4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end
            // long receiver stall while polls keep coming
            if (phase == 2)
                hold_off_req = 1'b1;
            for (int k = 0; k < POLLS_PER_PHASE; k++)
                send_poll(next_poll());
        end

        settle();
        if (sb.failures == 0)
            $display("tag_presence_qualifier_unit_tb: PASS");
        else
            $display("tag_presence_qualifier_unit_tb: FAIL");
        $finish;
    end

endmodule
